@@ rtl/core/rrfd_pkg.sv @@
// Shared types and codes for the record ring FIFO with tail drop.
package rrfd_pkg;

  // Request kinds
  localparam logic [1:0] KIND_OFFER = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NOT_RECORDING = 3'd1;
  localparam logic [2:0] ST_DROPPED       = 3'd2;
  localparam logic [2:0] ST_EMPTY         = 3'd3;
  localparam logic [2:0] ST_SEQUENCE      = 3'd4;

  // Configuration register indexes
  localparam logic REG_RECORDING_ENABLED = 1'b0;
  localparam logic REG_STORAGE_FULL      = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the request fields
    logic exec;   // apply the captured request to the ring state
  } ctrl_cmd_t;

endpackage

@@ rtl/core/rrfd_ctrl.sv @@
// Sequencing state machine: accept, execute, respond.
module rrfd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output rrfd_pkg::ctrl_cmd_t cmd
);
  import rrfd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: state_next = S_RESP;
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state != S_IDLE);
  assign done     = (state == S_RESP);
  assign cmd.load = start && (state == S_IDLE);
  assign cmd.exec = (state == S_EXEC);

endmodule

@@ rtl/core/rrfd_datapath.sv @@
// Ring memory, pointers, reservation tracking and counters.
module rrfd_datapath #(
  parameter int RING_DEPTH       = 16384,
  parameter int MAX_RECORD_BYTES = 263
) (
  input  logic                clk,
  input  logic                rst,
  input  rrfd_pkg::ctrl_cmd_t cmd,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic                cfg_wdata,
  input  logic [1:0]          kind,
  input  logic [8:0]          record_length,
  input  logic [7:0]          data_byte,
  output logic [2:0]          status,
  output logic [7:0]          read_data,
  output logic                read_valid,
  output logic [14:0]         fill_level,
  output logic [31:0]         dropped_count,
  output logic [63:0]         bytes_out_count
);
  import rrfd_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  logic [7:0]    mem [RING_DEPTH];
  logic [7:0]    mem_rdata;

  logic          rec_en;
  logic          st_full;

  logic [1:0]    kind_q;
  logic [8:0]    len_q;
  logic [7:0]    byte_q;

  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] committed;
  logic [8:0]    pend_left;
  logic [8:0]    pend_total;
  logic [31:0]   drop_cnt;
  logic [63:0]   bo_cnt;
  logic [2:0]    status_q;
  logic          rvalid_q;

  logic [CW-1:0] free_space;
  logic          mem_we;
  logic          mem_re;

  assign free_space = CW'(RING_DEPTH) - committed;
  assign mem_we = cmd.exec && (kind_q == KIND_BYTE) && (pend_left != 9'd0);
  assign mem_re = cmd.exec && (kind_q == KIND_READ) && (committed != '0);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_en  <= 1'b0;
      st_full <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RECORDING_ENABLED: rec_en  <= cfg_wdata;
        REG_STORAGE_FULL:      st_full <= cfg_wdata;
        default:               rec_en  <= rec_en;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      len_q  <= record_length;
      byte_q <= data_byte;
    end
  end

  // ring memory, registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= byte_q;
    end
    if (mem_re) begin
      mem_rdata <= mem[rp];
    end
  end

  // ring state update
  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      committed  <= '0;
      pend_left  <= '0;
      pend_total <= '0;
      drop_cnt   <= '0;
      bo_cnt     <= '0;
      status_q   <= ST_OK;
      rvalid_q   <= 1'b0;
    end else if (cmd.exec) begin
      status_q <= ST_OK;
      rvalid_q <= 1'b0;
      unique case (kind_q)
        KIND_OFFER: begin
          if (pend_left != 9'd0) begin
            status_q <= ST_SEQUENCE;
          end else if (!rec_en) begin
            status_q <= ST_NOT_RECORDING;
          end else if (st_full || (len_q > 9'(MAX_RECORD_BYTES)) ||
                       (CW'(len_q) > free_space)) begin
            drop_cnt <= drop_cnt + 32'd1;
            status_q <= ST_DROPPED;
          end else begin
            pend_left  <= len_q;
            pend_total <= len_q;
          end
        end
        KIND_BYTE: begin
          if (pend_left == 9'd0) begin
            status_q <= ST_SEQUENCE;
          end else begin
            wp        <= (wp == PW'(RING_DEPTH - 1)) ? '0 : wp + PW'(1);
            pend_left <= pend_left - 9'd1;
            // last byte of the record commits the whole reservation
            if (pend_left == 9'd1) begin
              committed  <= committed + CW'(pend_total);
              pend_total <= '0;
            end
          end
        end
        KIND_READ: begin
          if (committed == '0) begin
            status_q <= ST_EMPTY;
          end else begin
            rvalid_q  <= 1'b1;
            rp        <= (rp == PW'(RING_DEPTH - 1)) ? '0 : rp + PW'(1);
            committed <= committed - CW'(1);
            bo_cnt    <= bo_cnt + 64'd1;
          end
        end
        KIND_CLEAR: begin
          wp         <= '0;
          rp         <= '0;
          committed  <= '0;
          pend_left  <= '0;
          pend_total <= '0;
          drop_cnt   <= '0;
          bo_cnt     <= '0;
        end
        default: status_q <= ST_OK;
      endcase
    end
  end

  assign status          = status_q;
  assign read_valid      = rvalid_q;
  assign read_data       = rvalid_q ? mem_rdata : 8'd0;
  assign fill_level      = 15'(committed);
  assign dropped_count   = drop_cnt;
  assign bytes_out_count = bo_cnt;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    committed <= CW'(RING_DEPTH))
    else $error("committed bytes exceed ring depth");

  a_pend_order: assert property (@(posedge clk) disable iff (rst)
    pend_left <= pend_total)
    else $error("bytes left exceed reserved total");

  a_rvalid_ok: assert property (@(posedge clk) disable iff (rst)
    rvalid_q |-> (status_q == ST_OK))
    else $error("popped byte with non-ok status");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (kind_q == KIND_CLEAR)) |=>
      (committed == '0 && pend_left == 9'd0 && drop_cnt == 32'd0 && bo_cnt == 64'd0))
    else $error("clear left state behind");
`endif

endmodule

@@ rtl/core/record_ring_fifo_with_drop_unit.sv @@
// Top level: byte ring FIFO taking whole records or dropping them.
// Sequence: the accepting edge captures the request, EXEC applies it, and done pulses in RESP.
// A new request is taken only back in IDLE; busy covers execute and respond.
// The execute step drives the ring memory's write port and its registered read port.
// Reset (rst, synchronous): pointers, fill, reservation, counters, config cleared.
// Memory contents are not cleared; only committed bytes are ever read back.
module record_ring_fifo_with_drop_unit #(
  parameter int RING_DEPTH       = 16384,
  parameter int MAX_RECORD_BYTES = 263
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [8:0]  record_length,
  input  logic [7:0]  data_byte,
  // result channel, one-cycle strobe, cannot be stalled
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  read_data,
  output logic        read_valid,
  output logic [14:0] fill_level,
  output logic [31:0] dropped_count,
  output logic [63:0] bytes_out_count,
  // config write port: index 0 recording_enabled, index 1 storage_full
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic        cfg_wdata
);
  import rrfd_pkg::*;

  ctrl_cmd_t cmd;

  // sequencing: IDLE accepts, EXEC updates ring state, RESP presents result
  rrfd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // ring memory, pointers, reservation and counters
  rrfd_datapath #(
    .RING_DEPTH       (RING_DEPTH),
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .kind            (kind),
    .record_length   (record_length),
    .data_byte       (data_byte),
    .status          (status),
    .read_data       (read_data),
    .read_valid      (read_valid),
    .fill_level      (fill_level),
    .dropped_count   (dropped_count),
    .bytes_out_count (bytes_out_count)
  );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for record_ring_fifo_with_drop_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrfd_pkg::*;

  localparam int RING_CAP    = 16384;
  localparam int LONGEST_REC = 263;
  // Cycles with no request and no result before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;

  // One request as driven, plus optional hand-typed expectation or a config write.
  typedef struct {
    logic       cfg;       // row is a register write, not a request
    logic       reg_idx;
    logic       reg_val;
    logic [1:0] kind;
    logic [8:0] len;
    logic [7:0] dbyte;
    logic       typed;     // status and fill below override the mirror
    logic [2:0] st;
    logic [14:0] fill;
  } ring_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  rdata;
    logic        rvalid;
    logic [14:0] fill;
    logic [31:0] drops;
    logic [63:0] outs;
  } ring_ans_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  kind = KIND_OFFER;
  logic [8:0]  record_length = '0;
  logic [7:0]  data_byte = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = REG_RECORDING_ENABLED;
  logic        cfg_wdata = 1'b0;
  logic        busy;
  logic        done;
  logic [2:0]  status;
  logic [7:0]  read_data;
  logic        read_valid;
  logic [14:0] fill_level;
  logic [31:0] dropped_count;
  logic [63:0] bytes_out_count;

  always #6 clk = ~clk;

  record_ring_fifo_with_drop_unit dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .kind(kind), .record_length(record_length), .data_byte(data_byte),
    .done(done), .status(status), .read_data(read_data), .read_valid(read_valid),
    .fill_level(fill_level), .dropped_count(dropped_count),
    .bytes_out_count(bytes_out_count),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the ring: own copy of the memory, pointers, reservation, counters
  // ---------------------------------------------------------------------------
  logic [7:0]  mirror_mem [0:RING_CAP-1];
  logic [13:0] mirror_wr = '0;
  logic [13:0] mirror_rd = '0;
  logic [14:0] mirror_committed = '0;
  logic [8:0]  mirror_left = '0;      // bytes still due for the open record
  logic [8:0]  mirror_total = '0;     // size of the open record
  logic [31:0] mirror_drops = '0;
  logic [63:0] mirror_outs = '0;
  logic        mirror_rec_en = 1'b0;
  logic        mirror_full = 1'b0;

  ring_ans_t answers_due [$];         // answers owed by the DUT, oldest first
  ring_ans_t seen_exp;

  int errors = 0;
  int requests = 0;
  int results = 0;
  int reg_writes = 0;
  int peak_fill = 0;
  int idle_pct = 0;                   // sender gap odds, percent
  int quiet = 0;

  // Works out the answer to one request and moves the mirror on.
  function automatic ring_ans_t ring_apply(input ring_req_t r);
    ring_ans_t a;
    a = '{status: ST_OK, rdata: '0, rvalid: 1'b0, fill: '0, drops: '0, outs: '0};
    case (r.kind)
      KIND_OFFER: begin
        // Sequence check first, then recording, then the drop reasons.
        if (mirror_left != 0) begin
          a.status = ST_SEQUENCE;
        end else if (!mirror_rec_en) begin
          a.status = ST_NOT_RECORDING;
        end else if (mirror_full || int'(r.len) > LONGEST_REC ||
                     int'(r.len) > RING_CAP - int'(mirror_committed)) begin
          mirror_drops++;
          a.status = ST_DROPPED;
        end else begin
          mirror_left  = r.len;       // zero length reserves nothing
          mirror_total = r.len;
        end
      end
      KIND_BYTE: begin
        if (mirror_left == 0) begin
          a.status = ST_SEQUENCE;     // stray byte, discarded
        end else begin
          mirror_mem[mirror_wr] = r.dbyte;
          mirror_wr++;
          mirror_left--;
          // Whole record becomes readable on its last byte.
          if (mirror_left == 0) begin
            mirror_committed += 15'(mirror_total);
            mirror_total = '0;
          end
        end
      end
      KIND_READ: begin
        if (mirror_committed == 0) begin
          a.status = ST_EMPTY;
        end else begin
          a.rdata  = mirror_mem[mirror_rd];
          a.rvalid = 1'b1;
          mirror_rd++;
          mirror_committed--;
          mirror_outs++;
        end
      end
      default: begin
        // Clear: ring, reservation and both counters; registers untouched.
        mirror_wr = '0;
        mirror_rd = '0;
        mirror_committed = '0;
        mirror_left = '0;
        mirror_total = '0;
        mirror_drops = '0;
        mirror_outs = '0;
      end
    endcase
    a.fill  = mirror_committed;
    a.drops = mirror_drops;
    a.outs  = mirror_outs;
    if (int'(mirror_committed) > peak_fill) peak_fill = mirror_committed;
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Table rows
  // ---------------------------------------------------------------------------
  function automatic ring_req_t rq(input logic [1:0] k, input logic [8:0] l,
                                   input logic [7:0] b);
    ring_req_t r;
    r = '{cfg: 1'b0, reg_idx: 1'b0, reg_val: 1'b0, kind: k, len: l, dbyte: b,
          typed: 1'b0, st: ST_OK, fill: '0};
    return r;
  endfunction

  function automatic ring_req_t tq(input logic [1:0] k, input logic [8:0] l,
                                   input logic [7:0] b, input logic [2:0] st,
                                   input logic [14:0] fill);
    ring_req_t r;
    r = rq(k, l, b);
    r.typed = 1'b1;
    r.st = st;
    r.fill = fill;
    return r;
  endfunction

  function automatic ring_req_t cq(input logic idx, input logic val);
    ring_req_t r;
    r = rq(KIND_OFFER, '0, '0);
    r.cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Random request, mostly well-formed records with some noise mixed in.
  function automatic ring_req_t random_req();
    ring_req_t r;
    int pick;
    int lsel;
    r = rq(KIND_READ, 9'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    if (mirror_left != 0) begin
      if (pick < 85)      r.kind = KIND_BYTE;
      else if (pick < 90) r.kind = KIND_OFFER;     // offer inside a record
      else if (pick < 99) r.kind = KIND_READ;
      else                r.kind = KIND_CLEAR;     // cancels the reservation
    end else begin
      if (pick < 40)      r.kind = KIND_OFFER;
      else if (pick < 50) r.kind = KIND_BYTE;      // stray byte
      else if (pick < 97) r.kind = KIND_READ;
      else                r.kind = KIND_CLEAR;
    end
    if (r.kind == KIND_OFFER) begin
      lsel = $urandom_range(0, 99);
      if (lsel < 70)      r.len = 9'($urandom_range(0, 12));
      else if (lsel < 84) r.len = 9'($urandom_range(13, LONGEST_REC));
      else if (lsel < 94) r.len = 9'($urandom_range(LONGEST_REC + 1, 511));
      else if (lsel < 96) r.len = '0;
      else if (lsel < 98) r.len = 9'(LONGEST_REC);
      else                r.len = 9'h1FF;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------------
  // Drives one request and waits for the accepting edge (start high, busy low).
  task automatic send_req(input ring_req_t r);
    ring_ans_t a;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    kind <= r.kind;
    record_length <= r.len;
    data_byte <= r.dbyte;
    do @(posedge clk); while (busy);
    a = ring_apply(r);
    if (r.typed) begin
      a.status = r.st;
      a.fill = r.fill;
    end
    answers_due.push_back(a);
    requests++;
  endtask

  // Sender holds off until every owed answer is in, then a little latency slack.
  task automatic wait_idle();
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RECORDING_ENABLED) mirror_rec_en = val;
    else mirror_full = val;
    reg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every done strobe is one result, checked against the oldest
  // ---------------------------------------------------------------------------
  task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch on result %0d, %s: expected %0h, got %0h", results, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        flag("unrequested result, status", '0, status);
      end else begin
        seen_exp = answers_due.pop_front();
        if (status !== seen_exp.status)          flag("status", seen_exp.status, status);
        if (read_data !== seen_exp.rdata)        flag("read_data", seen_exp.rdata, read_data);
        if (read_valid !== seen_exp.rvalid)      flag("read_valid", seen_exp.rvalid, read_valid);
        if (fill_level !== seen_exp.fill)        flag("fill_level", seen_exp.fill, fill_level);
        if (dropped_count !== seen_exp.drops)    flag("dropped_count", seen_exp.drops,
                                                      dropped_count);
        if (bytes_out_count !== seen_exp.outs)   flag("bytes_out_count", seen_exp.outs,
                                                      bytes_out_count);
      end
      results++;
    end
  end

  // Watchdog: counts cycles in which neither a request nor a result is taken.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles, %0d answers owed",
                 QUIET_LIMIT, answers_due.size());
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  ring_req_t plan [$];
  int phase_idle [4] = '{0, 67, 0, 36};

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset state, every kind, each corner of the offer rules.
    plan.push_back(tq(KIND_READ,  '0, '0, ST_EMPTY, '0));           // empty after reset
    plan.push_back(tq(KIND_OFFER, 9'd5, '0, ST_NOT_RECORDING, '0)); // capture off
    plan.push_back(tq(KIND_BYTE,  '0, 8'hAA, ST_SEQUENCE, '0));     // stray byte
    plan.push_back(cq(REG_RECORDING_ENABLED, 1'b1));
    plan.push_back(tq(KIND_OFFER, 9'd0, '0, ST_OK, '0));            // empty record
    plan.push_back(tq(KIND_BYTE,  '0, 8'h55, ST_SEQUENCE, '0));     // nothing reserved
    plan.push_back(tq(KIND_OFFER, 9'd264, '0, ST_DROPPED, '0));     // just over max
    plan.push_back(tq(KIND_OFFER, 9'h1FF, '0, ST_DROPPED, '0));     // all length bits
    plan.push_back(tq(KIND_OFFER, 9'd3, '0, ST_OK, '0));
    plan.push_back(tq(KIND_OFFER, 9'd2, '0, ST_SEQUENCE, '0));      // offer mid-record
    plan.push_back(tq(KIND_BYTE,  '0, 8'h00, ST_OK, '0));
    plan.push_back(tq(KIND_BYTE,  '0, 8'hFF, ST_OK, '0));
    plan.push_back(cq(REG_RECORDING_ENABLED, 1'b0));                // stop mid-record
    plan.push_back(tq(KIND_BYTE,  '0, 8'h5A, ST_OK, 15'd3));        // still committed
    plan.push_back(rq(KIND_READ,  '0, '0));
    plan.push_back(rq(KIND_READ,  '0, '0));
    plan.push_back(rq(KIND_READ,  '0, '0));
    plan.push_back(tq(KIND_READ,  '0, '0, ST_EMPTY, '0));
    plan.push_back(tq(KIND_OFFER, 9'd4, '0, ST_NOT_RECORDING, '0));
    plan.push_back(cq(REG_RECORDING_ENABLED, 1'b1));
    plan.push_back(cq(REG_STORAGE_FULL, 1'b1));
    plan.push_back(tq(KIND_OFFER, 9'd1, '0, ST_DROPPED, '0));       // storage full
    plan.push_back(tq(KIND_OFFER, 9'd0, '0, ST_DROPPED, '0));       // full beats empty
    plan.push_back(cq(REG_STORAGE_FULL, 1'b0));
    plan.push_back(tq(KIND_OFFER, 9'd263, '0, ST_OK, '0));          // longest record
    plan.push_back(rq(KIND_BYTE,  '0, 8'h81));
    plan.push_back(tq(KIND_CLEAR, '0, '0, ST_OK, '0));              // cancels reservation
    plan.push_back(tq(KIND_BYTE,  '0, 8'h18, ST_SEQUENCE, '0));
    plan.push_back(rq(KIND_READ,  '0, '0));
    foreach (plan[i]) begin
      if (plan[i].cfg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_req(plan[i]);
    end

    // Random: four idling phases, register settings re-rolled between blocks.
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      for (int blk = 0; blk < 4; blk++) begin
        write_reg(REG_RECORDING_ENABLED, $urandom_range(0, 3) != 0);
        write_reg(REG_STORAGE_FULL, $urandom_range(0, 4) == 0);
        repeat (44) send_req(random_req());
      end
    end

    // Wind down: every owed answer in, then the latency slack.
    wait_idle();
    repeat (6) @(posedge clk);
    errors += answers_due.size();

    $display("covered %0d requests and %0d results across %0d register writes,",
             requests, results, reg_writes);
    $display("with the ring filled as far as %0d bytes; %0d mismatches", peak_fill, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rrfd_pkg.sv
rtl/core/rrfd_ctrl.sv
rtl/core/rrfd_datapath.sv
rtl/core/record_ring_fifo_with_drop_unit.sv
tb/sv/tb.sv
